// ----- hw/rtl/tsd_pkg.sv -----
// Package for the tar stream deframer: result record, parse mode and octal phase codes.
// Used by tsd_parse and tar_stream_deframer. Depends on nothing.
`default_nettype none

package tsd_pkg;

    // Fixed ustar layout
    localparam int unsigned BLOCK_BYTES     = 512;
    localparam int unsigned TRAILER_DEFAULT = 1024;
    localparam int unsigned SIZE_FIRST      = 124;
    localparam int unsigned SIZE_LAST       = 135;

    localparam int unsigned CNT_W  = 9;   // header byte index, pad count
    localparam int unsigned SIZE_W = 36;  // twelve octal digits
    localparam int unsigned POS_W  = 32;

    // Parse mode, one-hot
    typedef enum logic [2:0] {
        MODE_HEADER  = 3'b001,
        MODE_PAYLOAD = 3'b010,
        MODE_PAD     = 3'b100
    } mode_t;

    // Size field parse phase, one-hot
    typedef enum logic [2:0] {
        PH_BEFORE = 3'b001,
        PH_DIGITS = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    // One result transaction
    typedef struct packed {
        logic [7:0]        out_byte;
        logic              byte_kind;
        logic              entry_start;
        logic              entry_last;
        logic [SIZE_W-1:0] entry_size;
        logic              size_valid;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tar_stream_deframer.sv -----
// Top level of the tar stream deframer: config register, stream position, trailer drop,
// output register. Depends on tsd_pkg and tsd_parse.
//
// Usage:
//  - Input channel (s_valid/s_ready): one byte of a decompressed ustar stream per
//    transaction; s_stream_start marks the first byte of a new archive.
//  - Output channel (m_valid/m_ready): header bytes (byte_kind 0) and payload bytes
//    (byte_kind 1). Padding bytes and the trailer produce no transaction.
//    entry_size and size_valid appear on the last header byte of each entry.
//  - cfg_wr_en/cfg_wr_data write stream_length; when it is nonzero and at least
//    TRAILER_BYTES, bytes at positions from stream_length - TRAILER_BYTES on are dropped.
//    Write it only while the block is idle.
//  - Throughput: one byte per cycle while the receiver keeps up. A result's m_valid rises
//    in the cycle after its byte is accepted, set by the single output register after the per-byte decode.
//  - s_ready is high while the output register is empty or being taken; when the
//    receiver stalls with a result held, input stalls too.
//  - Reset clears the parse state, position, stream_length and the output valid.
`default_nettype none

module tar_stream_deframer #(
    parameter int unsigned TRAILER_BYTES = tsd_pkg::TRAILER_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration
    input  wire logic                        cfg_wr_en,
    input  wire logic [tsd_pkg::POS_W-1:0]   cfg_wr_data,
    // input stream
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [7:0]                  s_data_byte,
    input  wire logic                        s_stream_start,
    // result stream
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [7:0]                       m_out_byte,
    output logic                             m_byte_kind,
    output logic                             m_entry_start,
    output logic                             m_entry_last,
    output logic [tsd_pkg::SIZE_W-1:0]       m_entry_size,
    output logic                             m_size_valid
);

    localparam logic [tsd_pkg::POS_W-1:0] TRAILER = tsd_pkg::POS_W'(TRAILER_BYTES);

    logic [tsd_pkg::POS_W-1:0] thresh_reg;
    logic                      drop_en_reg;
    logic [tsd_pkg::POS_W-1:0] pos_reg, pos_eff;
    logic                      accept, drop, emit;
    logic                      out_valid_reg;
    tsd_pkg::result_t          result, out_reg;

    // Config: keep the drop threshold precomputed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg  <= '0;
            drop_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            thresh_reg  <= cfg_wr_data - TRAILER;
            drop_en_reg <= (cfg_wr_data != '0) && (cfg_wr_data >= TRAILER);
        end
    end

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Stream position, saturating
    assign pos_eff = s_stream_start ? '0 : pos_reg;
    assign drop    = drop_en_reg && (pos_eff >= thresh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (accept) begin
            pos_reg <= (&pos_eff) ? pos_eff : pos_eff + 1'b1;
        end
    end

    tsd_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (accept && s_stream_start),
        .step    (accept && !drop),
        .in_byte (s_data_byte),
        .emit    (emit),
        .result  (result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= emit && !drop;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_out_byte    = out_reg.out_byte;
    assign m_byte_kind   = out_reg.byte_kind;
    assign m_entry_start = out_reg.entry_start;
    assign m_entry_last  = out_reg.entry_last;
    assign m_entry_size  = out_reg.entry_size;
    assign m_size_valid  = out_reg.size_valid;

    // Size only reported on the closing header byte
    a_size_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_size_valid |-> !m_byte_kind)
        else $error("size reported on a payload byte");

    a_size_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_size_valid |-> m_entry_size == '0)
        else $error("entry size nonzero off the last header byte");

    a_start_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_entry_start |-> !m_byte_kind && !m_size_valid)
        else $error("entry start on wrong byte");

    // Dropped bytes never reach the output
    a_drop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && drop |=> !m_valid)
        else $error("trailer byte passed on");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

// ----- hw/rtl/tsd_parse.sv -----
// Header / payload / padding parser of the tar stream deframer, one byte per cycle while step is high.
// Depends on tsd_pkg.
`default_nettype none

module tsd_parse (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              clear,     // accepted byte starts a new archive
    input  wire logic              step,      // accepted byte is not a trailer byte
    input  wire logic [7:0]        in_byte,
    output logic                   emit,
    output tsd_pkg::result_t       result
);

    tsd_pkg::mode_t                  mode_reg, mode_next, mode_eff;
    tsd_pkg::phase_t                 phase_reg, phase_next, phase_eff;
    logic [tsd_pkg::CNT_W-1:0]       hdr_cnt_reg, hdr_cnt_next, hdr_cnt_eff;
    logic [tsd_pkg::SIZE_W-1:0]      accum_reg, accum_next, accum_eff;
    logic [tsd_pkg::SIZE_W-1:0]      pay_left_reg, pay_left_next, pay_left_eff, pay_dec;
    logic [tsd_pkg::CNT_W-1:0]       pad_left_reg, pad_left_next, pad_left_eff, pad_dec;
    logic [tsd_pkg::CNT_W-1:0]       size_rem;
    logic [tsd_pkg::CNT_W:0]         pad_fill;
    logic                            is_octal, is_blank, in_field;

    // State seen by this byte: cleared at the start of an archive
    always_comb begin
        if (clear) begin
            mode_eff     = tsd_pkg::MODE_HEADER;
            phase_eff    = tsd_pkg::PH_BEFORE;
            hdr_cnt_eff  = '0;
            accum_eff    = '0;
            pay_left_eff = '0;
            pad_left_eff = '0;
        end else begin
            mode_eff     = mode_reg;
            phase_eff    = phase_reg;
            hdr_cnt_eff  = hdr_cnt_reg;
            accum_eff    = accum_reg;
            pay_left_eff = pay_left_reg;
            pad_left_eff = pad_left_reg;
        end
    end

    assign is_octal = in_byte inside {[8'h30:8'h37]};
    assign is_blank = in_byte inside {8'h20, [8'h09:8'h0D]};
    assign in_field = hdr_cnt_eff inside {[tsd_pkg::CNT_W'(tsd_pkg::SIZE_FIRST):
                                           tsd_pkg::CNT_W'(tsd_pkg::SIZE_LAST)]};

    assign pay_dec  = (pay_left_eff != '0) ? pay_left_eff - 1'b1 : pay_left_eff;
    assign pad_dec  = (pad_left_eff != '0) ? pad_left_eff - 1'b1 : pad_left_eff;
    assign size_rem = accum_next[tsd_pkg::CNT_W-1:0];
    assign pad_fill = (tsd_pkg::CNT_W+1)'(tsd_pkg::BLOCK_BYTES) - {1'b0, size_rem};

    // Per-byte decode
    always_comb begin
        mode_next     = mode_eff;
        phase_next    = phase_eff;
        hdr_cnt_next  = hdr_cnt_eff;
        accum_next    = accum_eff;
        pay_left_next = pay_left_eff;
        pad_left_next = pad_left_eff;
        emit          = 1'b0;
        result        = '0;
        result.out_byte = in_byte;

        case (mode_eff)
            tsd_pkg::MODE_PAYLOAD: begin
                emit             = 1'b1;
                result.byte_kind = 1'b1;
                pay_left_next    = pay_dec;
                if (pay_dec == '0) begin
                    result.entry_last = 1'b1;
                    mode_next = (pad_left_eff != '0) ? tsd_pkg::MODE_PAD
                                                     : tsd_pkg::MODE_HEADER;
                end
            end
            tsd_pkg::MODE_PAD: begin
                pad_left_next = pad_dec;
                if (pad_dec == '0) begin
                    mode_next = tsd_pkg::MODE_HEADER;
                end
            end
            default: begin
                // Header byte
                emit = 1'b1;
                if (hdr_cnt_eff == '0) begin
                    accum_next         = '0;
                    phase_next         = tsd_pkg::PH_BEFORE;
                    result.entry_start = 1'b1;
                end
                // strtoul-style octal parse of the size field
                if (in_field && phase_next != tsd_pkg::PH_DONE &&
                    !(phase_next == tsd_pkg::PH_BEFORE && is_blank)) begin
                    if (is_octal) begin
                        accum_next = {accum_next[tsd_pkg::SIZE_W-4:0], in_byte[2:0]};
                        phase_next = tsd_pkg::PH_DIGITS;
                    end else begin
                        phase_next = tsd_pkg::PH_DONE;
                    end
                end
                if (hdr_cnt_eff == tsd_pkg::CNT_W'(tsd_pkg::BLOCK_BYTES - 1)) begin
                    result.entry_size = accum_next;
                    result.size_valid = 1'b1;
                    hdr_cnt_next      = '0;
                    if (accum_next == '0) begin
                        result.entry_last = 1'b1;
                        mode_next         = tsd_pkg::MODE_HEADER;
                    end else begin
                        pay_left_next = accum_next;
                        pad_left_next = (size_rem != '0) ? pad_fill[tsd_pkg::CNT_W-1:0] : '0;
                        mode_next     = tsd_pkg::MODE_PAYLOAD;
                    end
                end else begin
                    hdr_cnt_next = hdr_cnt_eff + 1'b1;
                end
            end
        endcase
    end

    // Parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= tsd_pkg::MODE_HEADER;
            phase_reg    <= tsd_pkg::PH_BEFORE;
            hdr_cnt_reg  <= '0;
            accum_reg    <= '0;
            pay_left_reg <= '0;
            pad_left_reg <= '0;
        end else if (step) begin
            mode_reg     <= mode_next;
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            accum_reg    <= accum_next;
            pay_left_reg <= pay_left_next;
            pad_left_reg <= pad_left_next;
        end else if (clear) begin
            mode_reg     <= mode_eff;
            phase_reg    <= phase_eff;
            hdr_cnt_reg  <= hdr_cnt_eff;
            accum_reg    <= accum_eff;
            pay_left_reg <= pay_left_eff;
            pad_left_reg <= pad_left_eff;
        end
    end

    // Payload mode is never entered with nothing left to pass
    a_payload_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == tsd_pkg::MODE_PAYLOAD |-> pay_left_reg != '0)
        else $error("payload mode with zero bytes left");

    // Pad mode is never entered with no padding left; padding never reaches a full block
    a_pad_short: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == tsd_pkg::MODE_PAD |-> pad_left_reg != '0)
        else $error("pad mode with zero bytes left");

    // Header count only moves in header mode
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !clear && mode_reg != tsd_pkg::MODE_HEADER |=> hdr_cnt_reg == '0)
        else $error("header count moved outside header mode");

endmodule

`default_nettype wire
